// ----- design/srcp_pkg.sv -----
`default_nettype none
package srcp_pkg;

  localparam logic [7:0] HdrB0 = 8'hf0;
  localparam logic [7:0] HdrB3 = 8'h7e;
  localparam logic [7:0] HdrB4 = 8'h4d;
  localparam logic [7:0] SysexEnd = 8'hf7;
  localparam logic [7:0] RealtimeMin = 8'hf8;
  localparam logic [7:0] CmdRemote = 8'h09;
  localparam logic [7:0] CmdLoopback = 8'h0e;
  localparam logic [7:0] CmdPing = 8'h0f;
  localparam logic [7:0] CodeWrongPort = 8'h7c;
  localparam logic [7:0] CodeIncomplete = 8'h7d;
  localparam logic [7:0] CodeNotAllowed = 8'h7e;
  localparam logic [7:0] CodeInvalid = 8'h7f;
  localparam logic [7:0] CodeUnknownCmd = 8'h0c;
  localparam logic [7:0] LcdColumns = 8'd80;

  localparam logic [1:0] RegDeviceId = 2'd0;
  localparam logic [1:0] RegConfMode = 2'd1;
  localparam logic [1:0] RegRemotePort = 2'd2;
  localparam logic [1:0] RegPeerId = 2'd3;

  localparam logic [1:0] KindTx = 2'd0;
  localparam logic [1:0] KindLcd = 2'd1;
  localparam logic [1:0] KindLed = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  // Message the back part expands into transmit beats.
  typedef enum logic [1:0] {
    MSG_NONE = 2'd0,
    MSG_ACK  = 2'd1,
    MSG_MODE = 2'd2
  } msg_e;

  // One classified step handed from the front part to the back part.
  typedef struct packed {
    logic       lcd_en;
    logic [7:0] lcd_char;
    logic [6:0] lcd_col;
    logic       lcd_row;
    logic       led_en;
    logic [3:0] led_val;
    logic [3:0] led_reg;
    logic       led_hi;
    msg_e       msg1;
    logic [7:0] ack_port;
    logic [7:0] ack_cmd;
    logic [7:0] ack_arg;
    logic       mode_req;
    logic [1:0] status;
    logic [1:0] amode;
    logic [7:0] aport;
    logic [2:0] rflags;
  } step_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACK  = 4'b0010,
    ST_MODE = 4'b0100,
    ST_STAT = 4'b1000
  } bstate_e;

endpackage
`default_nettype wire

// ----- design/srcp_front.sv -----
`default_nettype none
module srcp_front import srcp_pkg::*; #(
  parameter int LedRegisters = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       op_i,
  input  wire logic [7:0] port_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [6:0] device_id_i,
  input  wire logic [1:0] conf_mode_i,
  input  wire logic [7:0] remote_port_i,
  output step_t           step_o
);

  localparam logic [8:0] LedLimit = 9'(2 * LedRegisters);

  logic [2:0] hdr_cnt_q, hdr_cnt_d;
  logic       in_msg_q, in_msg_d;
  logic       cmd_seen_q, cmd_seen_d;
  logic [7:0] cmd_q, cmd_d;
  logic [3:0] rf_q, rf_d;
  logic [7:0] rcode_q, rcode_d;
  logic [7:0] px_q, px_d;
  logic [7:0] py_q, py_d;
  logic       ping_q, ping_d;
  logic [7:0] lport_q, lport_d;
  logic [1:0] amode_q, amode_d;
  logic [7:0] aport_q, aport_d;

  logic [7:0] hdr_exp;
  logic       autoc, autos, fin;
  step_t      s;

  always_comb begin
    case (hdr_cnt_q)
      3'd0:    hdr_exp = HdrB0;
      3'd3:    hdr_exp = HdrB3;
      3'd4:    hdr_exp = HdrB4;
      3'd5:    hdr_exp = {1'b0, device_id_i};
      default: hdr_exp = 8'h00;
    endcase
  end

  assign autoc = (conf_mode_i == 2'd0) || (conf_mode_i == 2'd2);
  assign autos = (conf_mode_i == 2'd0) || (conf_mode_i == 2'd1);

  always_comb begin
    hdr_cnt_d = hdr_cnt_q; in_msg_d = in_msg_q; cmd_seen_d = cmd_seen_q;
    cmd_d = cmd_q; rf_d = rf_q; rcode_d = rcode_q; px_d = px_q; py_d = py_q;
    ping_d = ping_q; lport_d = lport_q; amode_d = amode_q; aport_d = aport_q;
    fin = 1'b0;
    s = '0;
    s.msg1 = MSG_NONE;
    s.ack_port = port_i;
    s.status = 2'd1;
    if (op_i) begin
      if (in_msg_q && port_i == lport_q) fin = 1'b1;
    end else if (byte_i >= RealtimeMin) begin
      s.status = 2'd0;
    end else if (in_msg_q && port_i != lport_q) begin
      s.status = 2'd2;
    end else begin
      lport_d = port_i;
      if (!in_msg_q) begin
        if (byte_i != hdr_exp) fin = 1'b1;
        else begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == 3'd5) in_msg_d = 1'b1;
        end
      end else if (byte_i[7]) begin
        if (byte_i == SysexEnd && cmd_seen_q) begin
          if (cmd_q == CmdRemote) begin
            if (!rf_q[1]) begin
              s.msg1 = MSG_ACK; s.ack_cmd = CmdLoopback; s.ack_arg = rcode_q;
            end else if (!rf_q[2]) begin
              s.msg1 = MSG_ACK; s.ack_cmd = CmdLoopback; s.ack_arg = CodeIncomplete;
            end else if (!rf_q[3]) begin
              s.msg1 = MSG_ACK; s.ack_cmd = CmdPing; s.ack_arg = rcode_q;
            end
            s.mode_req = rf_q[1] && rf_q[2] && rcode_q == 8'd1;
          end else if (cmd_q == CmdPing && !ping_q) begin
            s.msg1 = MSG_ACK; s.ack_cmd = CmdPing; s.ack_arg = 8'h00;
          end
        end
        fin = 1'b1;
      end else if (!cmd_seen_q) begin
        cmd_seen_d = 1'b1;
        cmd_d = byte_i;
        if (byte_i == CmdRemote) begin
          rf_d = '0; rcode_d = CodeInvalid; px_d = 8'hff; py_d = 8'hff;
        end else if (byte_i == CmdPing) begin
          ping_d = 1'b0;
        end else if (byte_i != CmdLoopback) begin
          s.msg1 = MSG_ACK; s.ack_cmd = CmdLoopback; s.ack_arg = CodeUnknownCmd;
          fin = 1'b1;
        end
      end else if (cmd_q == CmdPing) begin
        ping_d = 1'b1;
      end else if (cmd_q == CmdRemote) begin
        if ((remote_port_i != 8'd0 && port_i != remote_port_i) ||
            (aport_q != 8'd0 && aport_q != port_i)) begin
          rcode_d = CodeWrongPort;
        end else if (!rf_q[0]) begin
          rcode_d = byte_i;
          rf_d[0] = 1'b1;
          if (byte_i == 8'd1) begin
            rf_d[2:1] = 2'b11; aport_d = port_i; s.rflags = 3'b011;
            if (autos) amode_d = 2'd1;
          end else if (byte_i >= 8'd2 && byte_i <= 8'd4) begin
            if (!autoc) rcode_d = CodeNotAllowed;
            else begin
              rf_d[1] = 1'b1; amode_d = 2'd2; aport_d = port_i;
            end
          end else if (byte_i != 8'd0) begin
            rcode_d = CodeInvalid;
          end
        end else if (rcode_q == 8'd0) begin
          if (!rf_q[2]) begin
            rf_d[2] = 1'b1;
            if (byte_i == 8'd0) begin
              if (autoc) begin rf_d[1] = 1'b1; amode_d = 2'd0; aport_d = 8'd0; end
              else rcode_d = CodeNotAllowed;
            end else if (byte_i == 8'd1) begin
              if (autos) begin
                rf_d[1] = 1'b1; amode_d = 2'd1; aport_d = port_i; s.rflags = 3'b011;
              end else rcode_d = CodeNotAllowed;
            end else if (byte_i == 8'd2) begin
              if (autoc) begin
                rf_d[1] = 1'b1; amode_d = 2'd2; aport_d = port_i; s.rflags = 3'b100;
              end else rcode_d = CodeNotAllowed;
            end else begin
              rf_d[1] = 1'b0;
            end
          end
        end else if (rcode_q == 8'd2) begin
          if (px_q[7]) px_d = byte_i;
          else if (py_q[7]) py_d = byte_i;
          else begin
            rf_d[3:2] = 2'b11;
            if (px_q < LcdColumns && py_q < 8'd2) begin
              s.lcd_en = 1'b1; s.lcd_char = byte_i;
              s.lcd_col = px_q[6:0]; s.lcd_row = py_q[0];
              px_d = px_q + 8'd1;
            end
          end
        end else if (rcode_q == 8'd3) begin
          rf_d[2] = 1'b1;
        end else if (rcode_q == 8'd4) begin
          if (px_q[7]) px_d = byte_i;
          else begin
            rf_d[3:2] = 2'b11;
            if ({1'b0, px_q} < LedLimit) begin
              s.led_en = 1'b1; s.led_val = byte_i[3:0];
              s.led_reg = px_q[4:1]; s.led_hi = px_q[0];
              px_d = px_q + 8'd1;
            end
          end
        end
      end
    end
    if (fin) begin
      hdr_cnt_d = '0; in_msg_d = 1'b0; cmd_seen_d = 1'b0; cmd_d = '0; rf_d = '0;
      rcode_d = '0; px_d = '0; py_d = '0; ping_d = 1'b0;
    end
    s.amode = amode_d;
    s.aport = aport_d;
  end

  assign step_o = s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0; in_msg_q <= 1'b0; cmd_seen_q <= 1'b0; cmd_q <= '0;
      rf_q <= '0; rcode_q <= '0; px_q <= '0; py_q <= '0; ping_q <= 1'b0;
      lport_q <= '0; amode_q <= '0; aport_q <= '0;
    end else if (step_i) begin
      hdr_cnt_q <= hdr_cnt_d; in_msg_q <= in_msg_d; cmd_seen_q <= cmd_seen_d;
      cmd_q <= cmd_d; rf_q <= rf_d; rcode_q <= rcode_d; px_q <= px_d;
      py_q <= py_d; ping_q <= ping_d; lport_q <= lport_d; amode_q <= amode_d;
      aport_q <= aport_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/srcp_queue.sv -----
`default_nettype none
module srcp_queue import srcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire step_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output step_t      data_o,
  output logic       empty_o
);

  step_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ----- design/srcp_back.sv -----
`default_nettype none
module srcp_back import srcp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire step_t      step_i,
  input  wire logic       avail_i,
  output logic            take_o,
  input  wire logic [6:0] device_id_i,
  input  wire logic [7:0] remote_port_i,
  input  wire logic [6:0] peer_id_i,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      tx_port_o,
  output logic [7:0]      value_o,
  output logic [6:0]      lcd_column_o,
  output logic            lcd_row_o,
  output logic [3:0]      led_register_o,
  output logic            led_high_nibble_o,
  output logic            last_o,
  output logic [1:0]      step_status_o,
  output logic [1:0]      active_mode_o,
  output logic [7:0]      active_port_o,
  output logic [2:0]      refresh_flags_o
);

  // Sequencer walks one step: side write, ack bytes, mode request, status.
  bstate_e    st_q, st_d;
  logic [3:0] idx_q, idx_d;
  logic       side_done_q, side_done_d;
  logic [7:0] hb;
  logic       fire;
  logic       beat_ok;

  // In the idle state a beat is presented only while a side write is pending;
  // the cycle that picks the next state carries no beat.
  assign beat_ok = (st_q != ST_IDLE) ||
                   (!side_done_q && (step_i.lcd_en || step_i.led_en));
  assign empty_o = !(avail_i && beat_ok);
  assign fire    = !empty_o && pop_i;

  always_comb begin
    case (idx_q)
      4'd0:    hb = HdrB0;
      4'd3:    hb = HdrB3;
      4'd4:    hb = HdrB4;
      default: hb = 8'h00;
    endcase
  end

  always_comb begin
    kind_o = KindStatus; tx_port_o = '0; value_o = '0; lcd_column_o = '0;
    lcd_row_o = 1'b0; led_register_o = '0; led_high_nibble_o = 1'b0; last_o = 1'b0;
    step_status_o = '0; active_mode_o = '0; active_port_o = '0; refresh_flags_o = '0;
    st_d = st_q; idx_d = idx_q; side_done_d = side_done_q; take_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!side_done_q && step_i.lcd_en) begin
          kind_o = KindLcd; value_o = step_i.lcd_char;
          lcd_column_o = step_i.lcd_col; lcd_row_o = step_i.lcd_row;
          if (fire) side_done_d = 1'b1;
        end else if (!side_done_q && step_i.led_en) begin
          kind_o = KindLed; value_o = {4'h0, step_i.led_val};
          led_register_o = step_i.led_reg; led_high_nibble_o = step_i.led_hi;
          if (fire) side_done_d = 1'b1;
        end else begin
          if (avail_i) begin
            idx_d = '0;
            if (step_i.msg1 == MSG_ACK) st_d = ST_ACK;
            else if (step_i.mode_req) st_d = ST_MODE;
            else st_d = ST_STAT;
          end
        end
      end
      ST_ACK: begin
        kind_o = KindTx; tx_port_o = step_i.ack_port;
        case (idx_q)
          4'd5:    value_o = {1'b0, device_id_i};
          4'd6:    value_o = step_i.ack_cmd;
          4'd7:    value_o = step_i.ack_arg;
          4'd8:    value_o = SysexEnd;
          default: value_o = hb;
        endcase
        if (fire) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd8) begin
            idx_d = '0;
            st_d = step_i.mode_req ? ST_MODE : ST_STAT;
          end
        end
      end
      ST_MODE: begin
        kind_o = KindTx; tx_port_o = remote_port_i;
        case (idx_q)
          4'd5:    value_o = {1'b0, peer_id_i};
          4'd6:    value_o = CmdRemote;
          4'd7:    value_o = 8'h00;
          4'd8:    value_o = 8'h02;
          4'd9:    value_o = SysexEnd;
          default: value_o = hb;
        endcase
        if (fire) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd9) begin
            idx_d = '0;
            st_d = ST_STAT;
          end
        end
      end
      ST_STAT: begin
        last_o = 1'b1; step_status_o = step_i.status;
        active_mode_o = step_i.amode; active_port_o = step_i.aport;
        refresh_flags_o = step_i.rflags;
        if (fire) begin
          take_o = 1'b1; side_done_d = 1'b0; st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; idx_q <= '0; side_done_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; side_done_q <= side_done_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/sysex_remote_command_parser.sv -----
`default_nettype none
// SysEx remote-command parser. Every accepted beat is one MIDI byte or a parser
// timeout on a port; the front part parses it in the cycle it is accepted and
// queues a compact step record (two deep), and the back part turns that record
// into result beats: an optional LCD or LED write, up to two messages (a
// nine-byte ack and a ten-byte client mode request), and a closing status beat
// with last set. The front part accepts one input beat per cycle while the
// queue has room. The back part delivers one result beat per cycle while pop
// is asserted, but on every step, after its optional side write, it presents
// no beat while its idle state picks the next state. Configuration written
// through the register port is used by both parts and must only change while
// the block is idle.
module sysex_remote_command_parser import srcp_pkg::*; #(
  parameter int LED_REGISTERS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic       operation_i,
  input  wire logic [7:0] port_i,
  input  wire logic [7:0] data_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      kind_o,
  output logic [7:0]      tx_port_o,
  output logic [7:0]      value_o,
  output logic [6:0]      lcd_column_o,
  output logic            lcd_row_o,
  output logic [3:0]      led_register_o,
  output logic            led_high_nibble_o,
  output logic            last_o,
  output logic [1:0]      step_status_o,
  output logic [1:0]      active_mode_o,
  output logic [7:0]      active_port_o,
  output logic [2:0]      refresh_flags_o
);

  logic [6:0] dev_id_q, peer_id_q;
  logic [1:0] conf_mode_q;
  logic [7:0] rport_q;
  logic       accept, q_empty, take;
  step_t      fstep, bstep;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= '0; conf_mode_q <= '0; rport_q <= '0; peer_id_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegDeviceId:   dev_id_q <= cfg_data_i[6:0];
        RegConfMode:   conf_mode_q <= cfg_data_i[1:0];
        RegRemotePort: rport_q <= cfg_data_i;
        RegPeerId:     peer_id_q <= cfg_data_i[6:0];
        default:       dev_id_q <= dev_id_q;
      endcase
    end
  end

  assign accept = push && !full;

  srcp_front #(.LedRegisters(LED_REGISTERS)) u_front (
    .clk_i, .rst_ni, .step_i(accept), .op_i(operation_i), .port_i,
    .byte_i(data_byte_i), .device_id_i(dev_id_q), .conf_mode_i(conf_mode_q),
    .remote_port_i(rport_q), .step_o(fstep)
  );

  srcp_queue u_queue (
    .clk_i, .rst_ni, .push_i(accept), .data_i(fstep), .full_o(full),
    .pop_i(take), .data_o(bstep), .empty_o(q_empty)
  );

  srcp_back u_back (
    .clk_i, .rst_ni, .step_i(bstep), .avail_i(!q_empty), .take_o(take),
    .device_id_i(dev_id_q), .remote_port_i(rport_q), .peer_id_i(peer_id_q),
    .empty_o(empty), .pop_i(pop), .kind_o, .tx_port_o, .value_o, .lcd_column_o,
    .lcd_row_o, .led_register_o, .led_high_nibble_o, .last_o, .step_status_o,
    .active_mode_o, .active_port_o, .refresh_flags_o
  );

`ifndef NO_ASSERTIONS
  // A step record leaves the queue only on its closing status beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (pop && !empty && last_o && kind_o == KindStatus))
    else $error("step retired without status beat");
  // The status beat is always the last one and never carries a side write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> kind_o == KindStatus)
    else $error("last flag on non-status beat");
  // Full means both queue slots hold unfinished steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !q_empty)
    else $error("queue full and empty");
`endif

endmodule
`default_nettype wire
